[rtl/periodic_weighted_spawn_picker_unit_defines.svh]
// Assertion macros for the periodic weighted spawn picker unit.
// Used by modules that have clk and arst_n in scope; no other dependencies.
`ifndef PERIODIC_WEIGHTED_SPAWN_PICKER_UNIT_DEFINES_SVH
`define PERIODIC_WEIGHTED_SPAWN_PICKER_UNIT_DEFINES_SVH

// same-cycle implication
`define PWSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PWSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pwsp_pkg.sv]
// Shared types and constants of the periodic weighted spawn picker unit.
// No dependencies.
package pwsp_pkg;

	localparam int MAX_KINDS_DEF   = 8;
	localparam int WEIGHT_BITS_DEF = 8;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 64;
	localparam int RAND_W          = 31;
	localparam int DIV_W           = 16;
	localparam int DIV_STEPS       = 16;   // two quotient bits per step over 32 bits
	localparam int POS_W           = 18;

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_ENABLED  = 4'd0;
	localparam reg_idx_t REG_INTERVAL = 4'd1;
	localparam reg_idx_t REG_WEIGHTS  = 4'd2;
	localparam reg_idx_t REG_KINDS    = 4'd3;
	localparam reg_idx_t REG_AREA_X   = 4'd4;
	localparam reg_idx_t REG_AREA_Y   = 4'd5;
	localparam reg_idx_t REG_AREA_W   = 4'd6;
	localparam reg_idx_t REG_AREA_H   = 4'd7;

	typedef enum logic [1:0] {
		SEL_PICK,
		SEL_X,
		SEL_Y
	} pwsp_sel_t;

	typedef struct packed {
		logic      capture;
		logic      acc_clear;
		logic      acc_add;
		logic      acc_sub;
		logic      div_load;
		logic      div_step;
		logic      store;
		logic      out_load;
		pwsp_sel_t load_sel;
		pwsp_sel_t sel;
	} pwsp_cmd_t;

	typedef struct packed {
		logic run_ok;
		logic over;
		logic sum_zero;
	} pwsp_stat_t;

endpackage

[rtl/periodic_weighted_spawn_picker_unit.sv]
// Periodic weighted spawn picker, top level: controller plus datapath.
// Depends on pwsp_pkg, pwsp_ctrl and pwsp_dp.
//
// Each input word is a tick; the block takes one tick at a time. A tick that
// gives no event returns to idle from the accumulate state when the block
// is disabled or the interval is zero, and from the compare state when the
// interval is not yet passed or no kind in use has weight. A tick that
// gives an event runs accumulate and compare, then three remainders on one
// shared remainder unit that retires two bits a cycle, each followed by its
// store (kind, then x, then y), and finally the load of the output
// word. The output word is registered, so a finished event may wait for the
// consumer while the next tick is already taken; the block only stalls when a
// second event is ready before the first was taken. Configuration is always
// ready; writes to unknown register indexes are ignored.
module periodic_weighted_spawn_picker_unit
	import pwsp_pkg::*;
#(
	parameter int MAX_KINDS   = MAX_KINDS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [15:0]             time_step,
	input  logic [RAND_W-1:0]       rand_pick,
	input  logic [RAND_W-1:0]       rand_x,
	input  logic [RAND_W-1:0]       rand_y,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              kind_index,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y
);

	pwsp_cmd_t  cmd;
	pwsp_stat_t stat;

	assign cfg_ready = 1'b1;

	pwsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pwsp_dp #(
		.MAX_KINDS   (MAX_KINDS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.time_step  (time_step),
		.rand_pick  (rand_pick),
		.rand_x     (rand_x),
		.rand_y     (rand_y),
		.cmd        (cmd),
		.stat       (stat),
		.kind_index (kind_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y)
	);

endmodule

[rtl/pwsp_ctrl.sv]
// Sequencer of the spawn picker: accumulate, compare, three remainders, output.
// Depends on pwsp_pkg and the assertion macro header.
`include "periodic_weighted_spawn_picker_unit_defines.svh"

module pwsp_ctrl
	import pwsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  pwsp_stat_t stat,
	output pwsp_cmd_t  cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_CMP,
		S_DIV,
		S_STORE,
		S_OUT
	} state_t;

	state_t           state_q;
	pwsp_sel_t        sel_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.sel      = sel_q;
		cmd.load_sel = SEL_PICK;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
			end
			S_ACC: begin
				cmd.acc_clear = !stat.run_ok;
				cmd.acc_add   = stat.run_ok;
			end
			S_CMP: begin
				cmd.acc_sub  = stat.over;
				cmd.div_load = stat.over && !stat.sum_zero;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_STORE: begin
				cmd.store    = 1'b1;
				cmd.div_load = (sel_q != SEL_Y);
				cmd.load_sel = (sel_q == SEL_PICK) ? SEL_X : SEL_Y;
			end
			S_OUT: begin
				cmd.out_load = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= SEL_PICK;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cmd.div_load)
				sel_q <= cmd.load_sel;
			if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_ACC;
				S_ACC:   state_q <= stat.run_ok ? S_CMP : S_IDLE;
				S_CMP:   state_q <= (stat.over && !stat.sum_zero) ? S_DIV : S_IDLE;
				S_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= S_STORE;
				S_STORE: state_q <= (sel_q == SEL_Y) ? S_OUT : S_DIV;
				S_OUT:   if (cmd.out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PWSP_ASSERT_NEXT(a_accept_to_acc, in_valid && in_ready, state_q == S_ACC, "accept did not start accumulation")
	`PWSP_ASSERT_NOW(a_cnt_idle, state_q != S_DIV, cnt_q == '0, "step counter live outside remainder phase")
	`PWSP_ASSERT_NOW(a_out_free, cmd.out_load, !out_valid_q || out_ready, "output word overwritten")
	`PWSP_ASSERT_NEXT(a_out_set, cmd.out_load, out_valid_q && state_q == S_IDLE, "output load lost")

endmodule

[rtl/pwsp_dp.sv]
// Datapath of the spawn picker: config registers, accumulator, shared
// radix-4 remainder unit, roulette scan and output word. Depends on pwsp_pkg.
module pwsp_dp
	import pwsp_pkg::*;
#(
	parameter int MAX_KINDS   = MAX_KINDS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  reg_idx_t                cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic [15:0]             time_step,
	input  logic [RAND_W-1:0]       rand_pick,
	input  logic [RAND_W-1:0]       rand_x,
	input  logic [RAND_W-1:0]       rand_y,
	input  pwsp_cmd_t               cmd,
	output pwsp_stat_t              stat,
	output logic [2:0]              kind_index,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y
);

	localparam int SUM_W = $clog2(MAX_KINDS * ((1 << WEIGHT_BITS) - 1) + 1);

	logic        enabled_q;
	logic [31:0] interval_q;
	logic [63:0] weights_q;
	logic [3:0]  kinds_q;
	logic [15:0] area_x_q, area_y_q, area_w_q, area_h_q;

	logic [31:0]       elapsed_q;
	logic [15:0]       step_q;
	logic [RAND_W-1:0] rpick_q, rx_q, ry_q;
	logic [31:0]       quo_q;
	logic [DIV_W-1:0]  rem_q, dvs_q;
	logic [2:0]        kind_q;
	logic [DIV_W-1:0]  offx_q, offy_q;
	logic [2:0]        kind_out_q;
	logic [POS_W-1:0]  pos_x_q, pos_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b0;
			interval_q <= '0;
			weights_q  <= '0;
			kinds_q    <= '0;
			area_x_q   <= '0;
			area_y_q   <= '0;
			area_w_q   <= 16'd1;
			area_h_q   <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLED:  enabled_q  <= cfg_data[0];
				REG_INTERVAL: interval_q <= cfg_data[31:0];
				REG_WEIGHTS:  weights_q  <= cfg_data;
				REG_KINDS:    kinds_q    <= cfg_data[3:0];
				REG_AREA_X:   area_x_q   <= cfg_data[15:0];
				REG_AREA_Y:   area_y_q   <= cfg_data[15:0];
				REG_AREA_W:   area_w_q   <= cfg_data[15:0];
				REG_AREA_H:   area_h_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// running weight totals over the kinds in use
	logic [3:0]       n_c;
	logic [SUM_W-1:0] cum_c [MAX_KINDS];
	logic [SUM_W-1:0] sum_c;
	logic [SUM_W-1:0] r_c;
	logic [2:0]       pick_c;
	logic             found_c;

	always_comb begin
		n_c = (kinds_q > 4'(MAX_KINDS)) ? 4'(MAX_KINDS) : kinds_q;
		for (int i = 0; i < MAX_KINDS; i++) begin
			cum_c[i] = (i == 0) ? '0 : cum_c[(i == 0) ? 0 : i - 1];
			if (4'(i) < n_c)
				cum_c[i] = cum_c[i] + SUM_W'(weights_q[8*i +: WEIGHT_BITS]);
		end
		sum_c = cum_c[MAX_KINDS-1];
	end

	always_comb begin
		r_c     = rem_q[SUM_W-1:0] + SUM_W'(1);
		pick_c  = '0;
		found_c = 1'b0;
		for (int i = 0; i < MAX_KINDS; i++) begin
			if (!found_c && r_c <= cum_c[i]) begin
				pick_c  = 3'(i);
				found_c = 1'b1;
			end
		end
	end

	logic [32:0]      acc_sum_c;
	logic [DIV_W:0]   t1_c, t2_c;
	logic [DIV_W-1:0] r1_c, r2_c;

	assign acc_sum_c = {1'b0, elapsed_q} + {17'd0, step_q};

	always_comb begin
		t1_c = {rem_q, quo_q[31]};
		r1_c = (t1_c >= {1'b0, dvs_q}) ? DIV_W'(t1_c - {1'b0, dvs_q}) : t1_c[DIV_W-1:0];
		t2_c = {r1_c, quo_q[30]};
		r2_c = (t2_c >= {1'b0, dvs_q}) ? DIV_W'(t2_c - {1'b0, dvs_q}) : t2_c[DIV_W-1:0];
	end

	assign stat.run_ok   = enabled_q && (interval_q != '0);
	assign stat.over     = elapsed_q > interval_q;
	assign stat.sum_zero = (sum_c == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			elapsed_q <= '0;
		else if (cmd.acc_clear)
			elapsed_q <= '0;
		else if (cmd.acc_add)
			elapsed_q <= acc_sum_c[32] ? '1 : acc_sum_c[31:0];
		else if (cmd.acc_sub)
			elapsed_q <= elapsed_q - interval_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			step_q  <= time_step;
			rpick_q <= rand_pick;
			rx_q    <= rand_x;
			ry_q    <= rand_y;
		end
		if (cmd.div_load) begin
			rem_q <= '0;
			case (cmd.load_sel)
				SEL_X: begin
					quo_q <= {1'b0, rx_q};
					dvs_q <= area_w_q;
				end
				SEL_Y: begin
					quo_q <= {1'b0, ry_q};
					dvs_q <= area_h_q;
				end
				default: begin
					quo_q <= {1'b0, rpick_q};
					dvs_q <= DIV_W'(sum_c);
				end
			endcase
		end else if (cmd.div_step) begin
			rem_q <= r2_c;
			quo_q <= {quo_q[29:0], 2'b00};
		end
		if (cmd.store) begin
			case (cmd.sel)
				SEL_X:   offx_q <= (area_w_q != '0) ? rem_q : '0;
				SEL_Y:   offy_q <= (area_h_q != '0) ? rem_q : '0;
				default: kind_q <= pick_c;
			endcase
		end
		if (cmd.out_load) begin
			kind_out_q <= kind_q;
			pos_x_q    <= {{2{area_x_q[15]}}, area_x_q} + {2'b00, offx_q};
			pos_y_q    <= {{2{area_y_q[15]}}, area_y_q} + {2'b00, offy_q};
		end
	end

	assign kind_index = kind_out_q;
	assign pos_x      = pos_x_q;
	assign pos_y      = pos_y_q;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for periodic_weighted_spawn_picker_unit.
// Directed ticks, a long accumulate run, then random phases
// checked against a spawn predictor. Depends on pwsp_pkg and the unit.
module tb_top
	import pwsp_pkg::*;
();

	localparam int unsigned LIMIT        = 2_000_000;
	localparam int          DRAIN_CYCLES = 64;
	localparam int          SOAK_TICKS   = 40;
	localparam int          PHASES       = 8;
	localparam int          PHASE_TICKS  = 218;

	typedef struct packed {
		logic [15:0]       step;
		logic [RAND_W-1:0] pick;
		logic [RAND_W-1:0] x;
		logic [RAND_W-1:0] y;
	} tick_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} spawn_t;

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    cfg_valid  = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index  = '0;
	logic [CFG_DATA_W-1:0]   cfg_data   = '0;
	logic                    in_valid   = 1'b0;
	logic                    in_ready;
	logic [15:0]             time_step  = '0;
	logic [RAND_W-1:0]       rand_pick  = '0;
	logic [RAND_W-1:0]       rand_x     = '0;
	logic [RAND_W-1:0]       rand_y     = '0;
	logic                    out_valid;
	logic                    out_ready  = 1'b0;
	logic [2:0]              kind_index;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;

	// register copies and accumulator of the predictor
	logic        shadow_enabled  = 1'b0;
	logic [31:0] shadow_interval = '0;
	logic [63:0] shadow_weights  = '0;
	logic [3:0]  shadow_kinds    = '0;
	logic [15:0] shadow_area_x   = '0;
	logic [15:0] shadow_area_y   = '0;
	logic [15:0] shadow_area_w   = 16'd1;
	logic [15:0] shadow_area_h   = 16'd1;
	logic [31:0] elapsed_acc     = '0;

	tick_t       tick_pending_q[$];
	spawn_t      spawn_expected_q[$];
	bit          tick_taken     = 1'b0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          error_cnt      = 0;
	int unsigned cycle_cnt      = 0;

	int send_pct_tbl[4] = '{0, 49, 0, 34};
	int recv_pct_tbl[4] = '{0, 0, 49, 34};

	periodic_weighted_spawn_picker_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.time_step (time_step),
		.rand_pick (rand_pick),
		.rand_x    (rand_x),
		.rand_y    (rand_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind_index(kind_index),
		.pos_x     (pos_x),
		.pos_y     (pos_y)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == LIMIT) begin
			$display("periodic_weighted_spawn_picker_unit verification failed");
			$finish;
		end
	end

	function automatic void apply_reg(input reg_idx_t idx, input logic [63:0] data);
		case (idx)
			REG_ENABLED: begin
				shadow_enabled = data[0];
			end
			REG_INTERVAL: begin
				shadow_interval = data[31:0];
			end
			REG_WEIGHTS: begin
				shadow_weights = data;
			end
			REG_KINDS: begin
				shadow_kinds = data[3:0];
			end
			REG_AREA_X: begin
				shadow_area_x = data[15:0];
			end
			REG_AREA_Y: begin
				shadow_area_y = data[15:0];
			end
			REG_AREA_W: begin
				shadow_area_w = data[15:0];
			end
			REG_AREA_H: begin
				shadow_area_h = data[15:0];
			end
			default: begin
			end
		endcase
	endfunction

	// advances the accumulator; returns 1 when the tick spawns
	function automatic bit predict_spawn(input tick_t t, output spawn_t s);
		logic [32:0] acc_sum;
		int unsigned n;
		int unsigned wsum;
		int unsigned r;
		int unsigned cursor;
		int          ox;
		int          oy;
		int          ax;
		int          ay;
		int          px;
		int          py;
		bit          found;
		logic [2:0]  pick;
		s = '0;
		if (!shadow_enabled || shadow_interval == 0) begin
			elapsed_acc = '0;
			return 1'b0;
		end
		acc_sum = {1'b0, elapsed_acc} + {17'd0, t.step};
		elapsed_acc = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
		if (elapsed_acc <= shadow_interval)
			return 1'b0;
		elapsed_acc = elapsed_acc - shadow_interval;
		n = (shadow_kinds > 4'd8) ? 8 : shadow_kinds;
		wsum = 0;
		for (int i = 0; i < n; i++)
			wsum += shadow_weights[8*i +: 8];
		if (wsum == 0)
			return 1'b0;
		r = (32'(t.pick) % wsum) + 1;
		cursor = 0;
		pick = '0;
		found = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (!found) begin
				cursor += shadow_weights[8*i +: 8];
				if (r <= cursor) begin
					pick = i[2:0];
					found = 1'b1;
				end
			end
		end
		ox = (shadow_area_w != 0) ? int'(32'(t.x) % 32'(shadow_area_w)) : 0;
		oy = (shadow_area_h != 0) ? int'(32'(t.y) % 32'(shadow_area_h)) : 0;
		ax = $signed(shadow_area_x);
		ay = $signed(shadow_area_y);
		px = ax + ox;
		py = ay + oy;
		s.kind = pick;
		s.x = px[POS_W-1:0];
		s.y = py[POS_W-1:0];
		return 1'b1;
	endfunction

	// driver: ticks from the pending queue, plus consumer backpressure
	always @(negedge clk) begin : drive_inputs
		tick_t t;
		bit    go;
		if (arst_n && (!in_valid || tick_taken)) begin
			go = (tick_pending_q.size() != 0) && ($urandom_range(99, 0) >= send_idle_pct);
			if (go) begin
				t = tick_pending_q.pop_front();
				time_step <= t.step;
				rand_pick <= t.pick;
				rand_x    <= t.x;
				rand_y    <= t.y;
			end
			in_valid <= go;
		end
		out_ready <= arst_n && ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// monitor: check the result word first, then predict from the accepted tick
	always @(posedge clk) begin : watch_ports
		spawn_t want;
		spawn_t s;
		tick_t  t;
		tick_taken = arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (spawn_expected_q.size() == 0) begin
				$error("unexpected word: kind_index %0d pos_x %0d pos_y %0d",
					kind_index, pos_x, pos_y);
				error_cnt++;
			end else begin
				want = spawn_expected_q.pop_front();
				if (kind_index !== want.kind) begin
					$error("kind_index: expected %0d, actual %0d", want.kind, kind_index);
					error_cnt++;
				end
				if (pos_x !== want.x) begin
					$error("pos_x: expected %0d, actual %0d", $signed(want.x), pos_x);
					error_cnt++;
				end
				if (pos_y !== want.y) begin
					$error("pos_y: expected %0d, actual %0d", $signed(want.y), pos_y);
					error_cnt++;
				end
			end
		end
		if (tick_taken) begin
			t = {time_step, rand_pick, rand_x, rand_y};
			if (predict_spawn(t, s))
				spawn_expected_q.insert(spawn_expected_q.size(), s);
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
	endtask

	task automatic close_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_quiet();
		while (tick_pending_q.size() != 0 || in_valid || spawn_expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void queue_tick(input logic [15:0] step, input logic [RAND_W-1:0] p,
		input logic [RAND_W-1:0] x, input logic [RAND_W-1:0] y);
		tick_t t;
		t.step = step;
		t.pick = p;
		t.x = x;
		t.y = y;
		tick_pending_q.insert(tick_pending_q.size(), t);
	endfunction

	function automatic logic [RAND_W-1:0] rand_word();
		int sel;
		sel = $urandom_range(15, 0);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return RAND_W'($urandom);
	endfunction

	function automatic logic [15:0] rand_step();
		int sel;
		sel = $urandom_range(7, 0);
		if (sel == 0)
			return 16'd0;
		if (sel == 1)
			return 16'hFFFF;
		if (sel < 4)
			return 16'($urandom_range(255, 0));
		return 16'($urandom);
	endfunction

	function automatic logic [63:0] rand_weights();
		logic [63:0] w;
		w = {$urandom, $urandom};
		for (int i = 0; i < 8; i++)
			if ($urandom_range(3, 0) == 0)
				w[8*i +: 8] = '0;
		return w;
	endfunction

	task automatic setup_phase(input int ph);
		logic [31:0] iv;
		logic [3:0]  kinds;
		logic [63:0] w;
		case (ph % 4)
			0: iv = $urandom_range(4000, 1);
			1: iv = $urandom_range(70000, 20000);
			2: iv = $urandom_range(40, 1);
			default: iv = $urandom_range(30000, 1000);
		endcase
		kinds = (ph == 0) ? 4'd8 : (ph == 5) ? 4'd15 : 4'($urandom_range(15, 1));
		w = (ph == 5) ? '1 : rand_weights();
		write_reg(REG_ENABLED, {$urandom, $urandom} | 64'd1);
		write_reg(REG_INTERVAL, {$urandom, iv});
		write_reg(REG_WEIGHTS, w);
		write_reg(REG_KINDS, {$urandom, 28'd0, kinds});
		if (ph == 3) begin
			write_reg(REG_AREA_X, 64'h8000);
			write_reg(REG_AREA_Y, 64'h7FFF);
			write_reg(REG_AREA_W, 64'hFFFF);
			write_reg(REG_AREA_H, 64'hFFFF);
		end else begin
			write_reg(REG_AREA_X, {$urandom, $urandom});
			write_reg(REG_AREA_Y, {$urandom, $urandom});
			write_reg(REG_AREA_W, (ph == 6) ? 64'd0 : 64'($urandom_range(65535, 1)));
			write_reg(REG_AREA_H, 64'($urandom_range(65535, 1)));
		end
		if (ph % 2 == 1)
			write_reg(reg_idx_t'($urandom_range(15, 8)), {$urandom, $urandom});
		close_writes();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// disabled after reset
		queue_tick(16'hFFFF, '1, '1, '1);
		queue_tick(16'h0000, '0, '0, '0);
		wait_quiet();

		// enabled, zero interval
		write_reg(REG_ENABLED, '1);
		close_writes();
		queue_tick(16'd500, 31'd7, 31'd9, 31'd11);
		wait_quiet();

		// no kinds; elapsed equal to interval does not fire
		write_reg(REG_INTERVAL, 64'd100);
		write_reg(REG_KINDS, 64'd0);
		close_writes();
		queue_tick(16'd100, 31'd1, 31'd2, 31'd3);
		queue_tick(16'd50, 31'd1, 31'd2, 31'd3);
		wait_quiet();

		// kinds in use all weigh zero
		write_reg(REG_WEIGHTS, 64'hFFFF_FFFF_FFFF_0000);
		write_reg(REG_KINDS, 64'd2);
		close_writes();
		queue_tick(16'd200, 31'd5, 31'd5, 31'd5);
		wait_quiet();

		// oversized kind count, zero-weight kinds in between, area extremes
		write_reg(REG_WEIGHTS, 64'hFF00_0000_0300_0001);
		write_reg(REG_KINDS, 64'd15);
		write_reg(REG_AREA_X, 64'h8000);
		write_reg(REG_AREA_Y, 64'h7FFF);
		write_reg(REG_AREA_W, 64'hFFFF);
		write_reg(REG_AREA_H, 64'hFFFF);
		close_writes();
		queue_tick(16'd100, 31'd0, '0, '1);
		queue_tick(16'd100, 31'd1, '1, '0);
		queue_tick(16'd100, 31'd3, 31'd65534, 31'd65535);
		queue_tick(16'd100, 31'd4, 31'd65535, 31'd65534);
		queue_tick(16'd100, 31'd258, RAND_W'($urandom), RAND_W'($urandom));
		queue_tick(16'hFFFF, '1, RAND_W'($urandom), RAND_W'($urandom));
		wait_quiet();

		// zero area size, single kind
		write_reg(REG_AREA_W, 64'd0);
		write_reg(REG_AREA_H, 64'd0);
		write_reg(REG_KINDS, 64'd1);
		close_writes();
		queue_tick(16'd300, RAND_W'($urandom), RAND_W'($urandom), RAND_W'($urandom));
		queue_tick(16'd300, '1, '1, '1);
		wait_quiet();

		// only entry 1 weighs; unknown indexes change nothing
		write_reg(REG_WEIGHTS, 64'h0000_0000_0000_0100);
		write_reg(REG_KINDS, 64'd8);
		write_reg(reg_idx_t'(8), {$urandom, $urandom});
		write_reg(reg_idx_t'(15), '1);
		close_writes();
		queue_tick(16'd300, RAND_W'($urandom), RAND_W'($urandom), RAND_W'($urandom));
		queue_tick(16'd300, '1, RAND_W'($urandom), RAND_W'($urandom));
		wait_quiet();

		// disable clears the accumulator
		write_reg(REG_ENABLED, 64'hFFFF_FFFF_FFFF_FFFE);
		close_writes();
		queue_tick(16'hFFFF, RAND_W'($urandom), RAND_W'($urandom), RAND_W'($urandom));
		wait_quiet();

		// long accumulate run below the interval, then let it fire
		write_reg(REG_ENABLED, 64'd1);
		write_reg(REG_INTERVAL, 64'hFFFF_FFFF);
		write_reg(REG_WEIGHTS, 64'h0101_0101_0101_0101);
		write_reg(REG_AREA_W, 64'd1000);
		write_reg(REG_AREA_H, 64'd1000);
		close_writes();
		for (int i = 0; i < SOAK_TICKS; i++)
			queue_tick(16'hFFFF, RAND_W'($urandom), RAND_W'($urandom), RAND_W'($urandom));
		wait_quiet();
		write_reg(REG_INTERVAL, 64'd1_000_000);
		close_writes();
		for (int i = 0; i < 3; i++)
			queue_tick(16'hFFFF, RAND_W'($urandom), RAND_W'($urandom), RAND_W'($urandom));
		wait_quiet();

		for (int ph = 0; ph < PHASES; ph++) begin
			setup_phase(ph);
			send_idle_pct  = send_pct_tbl[ph % 4];
			recv_stall_pct = recv_pct_tbl[ph % 4];
			for (int i = 0; i < PHASE_TICKS; i++)
				queue_tick(rand_step(), rand_word(), rand_word(), rand_word());
			wait_quiet();
		end

		if (error_cnt == 0)
			$display("periodic_weighted_spawn_picker_unit verification clean");
		else
			$display("periodic_weighted_spawn_picker_unit verification failed");
		$finish;
	end

endmodule
